FILE: src/spml_pkg.sv
package spml_pkg;

  localparam int MAX_PATTERN_BYTES = 16;
  localparam int QUEUE_DEPTH       = 4;
  localparam int LEN_W             = 5;
  localparam int SKIP_W            = 4;
  localparam int CNT_W             = 32;
  localparam int CFG_INDEX_W       = 2;
  localparam int CFG_DATA_W        = 64;

  localparam logic [7:0] NEWLINE_CODE = 8'h0A;

  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LENGTH = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LOW    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_HIGH   = 2'd2;

  typedef struct packed {
    logic              elig;
    logic              newline;
    logic              equal;
    logic              last;
    logic [SKIP_W-1:0] len_m1;
    logic [CNT_W-1:0]  offset;
  } cand_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + CNT_W'(1);
  endfunction

  function automatic logic [7:0] pattern_byte(input logic [63:0] lo, input logic [63:0] hi,
                                              input logic [3:0] k);
    logic [63:0] word;
    word = k[3] ? hi : lo;
    return word[{k[2:0], 3'b000} +: 8];
  endfunction

endpackage

FILE: src/spml_front.sv
module spml_front #(
  parameter int MAX_PATTERN_BYTES = spml_pkg::MAX_PATTERN_BYTES
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [spml_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [spml_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [7:0]                          data_byte,
  input  logic                                last_byte,
  input  logic                                queue_full,
  output logic                                push,
  output spml_pkg::cand_t                     push_entry
);

  localparam int IDX_W = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;

  logic [spml_pkg::LEN_W-1:0]  pattern_length;
  logic [63:0]                 pattern_low_bytes;
  logic [63:0]                 pattern_high_bytes;
  logic [7:0]                  window [MAX_PATTERN_BYTES];
  logic [7:0]                  window_next [MAX_PATTERN_BYTES];
  logic [spml_pkg::CNT_W-1:0]  byte_position;
  logic [spml_pkg::LEN_W-1:0]  len_c;
  logic [spml_pkg::SKIP_W-1:0] len_m1;
  logic [MAX_PATTERN_BYTES-1:0] byte_eq;

  assign cfg_ready = 1'b1;
  assign in_ready  = !queue_full;
  assign push      = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length     <= '0;
      pattern_low_bytes  <= '0;
      pattern_high_bytes <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        spml_pkg::CFG_PATTERN_LENGTH: pattern_length     <= cfg_data[spml_pkg::LEN_W-1:0];
        spml_pkg::CFG_PATTERN_LOW:    pattern_low_bytes  <= cfg_data;
        spml_pkg::CFG_PATTERN_HIGH:   pattern_high_bytes <= cfg_data;
        default: ;
      endcase
    end
  end

  assign len_c  = (pattern_length > spml_pkg::LEN_W'(MAX_PATTERN_BYTES)) ?
                  spml_pkg::LEN_W'(MAX_PATTERN_BYTES) : pattern_length;
  assign len_m1 = spml_pkg::SKIP_W'(len_c - spml_pkg::LEN_W'(1));

  always_comb begin
    window_next[0] = data_byte;
    for (int j = 1; j < MAX_PATTERN_BYTES; j++) begin
      window_next[j] = window[j-1];
    end
  end

  for (genvar k = 0; k < MAX_PATTERN_BYTES; k++) begin : g_cmp
    logic [spml_pkg::SKIP_W-1:0] tap_idx;
    assign tap_idx    = len_m1 - spml_pkg::SKIP_W'(k);
    assign byte_eq[k] = (spml_pkg::SKIP_W'(k) > len_m1) ||
                        (window_next[tap_idx[IDX_W-1:0]] ==
                         spml_pkg::pattern_byte(pattern_low_bytes, pattern_high_bytes,
                                                4'(k)));
  end

  always_comb begin
    push_entry.elig    = (len_c != '0) &&
                         (byte_position >= spml_pkg::CNT_W'(len_m1));
    push_entry.newline = (window_next[len_m1[IDX_W-1:0]] == spml_pkg::NEWLINE_CODE);
    push_entry.equal   = &byte_eq;
    push_entry.last    = last_byte;
    push_entry.len_m1  = len_m1;
    push_entry.offset  = byte_position - spml_pkg::CNT_W'(len_m1);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      window <= window_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
    end else if (push) begin
      byte_position <= last_byte ? '0 : spml_pkg::sat_inc(byte_position);
    end
  end

endmodule

FILE: src/spml_queue.sv
module spml_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  spml_pkg::cand_t push_entry,
  output logic            full,
  input  logic            pop,
  output spml_pkg::cand_t head,
  output logic            empty
);

  localparam int DEPTH = spml_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  spml_pkg::cand_t  slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: src/spml_back.sv
module spml_back (
  input  logic                       clk,
  input  logic                       rst,
  input  spml_pkg::cand_t            head,
  input  logic                       empty,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       is_summary,
  output logic [spml_pkg::CNT_W-1:0] line_number,
  output logic [spml_pkg::CNT_W-1:0] match_offset,
  output logic [spml_pkg::CNT_W-1:0] match_total,
  output logic                       last_result
);

  logic [spml_pkg::SKIP_W-1:0] skip_remaining;
  logic [spml_pkg::CNT_W-1:0]  line_counter;
  logic [spml_pkg::CNT_W-1:0]  match_counter;
  logic                        pend_sum;

  logic                        out_free;
  logic                        active;
  logic                        hit;
  logic [spml_pkg::CNT_W-1:0]  line_next;
  logic [spml_pkg::CNT_W-1:0]  match_next;
  logic [spml_pkg::SKIP_W-1:0] skip_next;

  assign out_free = !out_valid || out_ready;
  assign pop      = out_free && !pend_sum && !empty;

  always_comb begin
    active     = head.elig && (skip_remaining == '0);
    hit        = active && head.equal;
    line_next  = (active && head.newline) ? spml_pkg::sat_inc(line_counter) : line_counter;
    match_next = hit ? spml_pkg::sat_inc(match_counter) : match_counter;
    if (!head.elig) begin
      skip_next = skip_remaining;
    end else if (skip_remaining != '0) begin
      skip_next = skip_remaining - spml_pkg::SKIP_W'(1);
    end else begin
      skip_next = hit ? head.len_m1 : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      pend_sum       <= 1'b0;
      skip_remaining <= '0;
      line_counter   <= spml_pkg::CNT_W'(1);
      match_counter  <= '0;
    end else begin
      priority if (pop && hit) begin
        out_valid      <= 1'b1;
        is_summary     <= 1'b0;
        line_number    <= line_next;
        match_offset   <= head.offset;
        match_total    <= match_next;
        last_result    <= !head.last;
        line_counter   <= line_next;
        match_counter  <= match_next;
        skip_remaining <= skip_next;
        pend_sum       <= head.last;
      end else if (pop && head.last) begin
        out_valid      <= 1'b1;
        is_summary     <= 1'b1;
        line_number    <= line_next;
        match_offset   <= '0;
        match_total    <= match_next;
        last_result    <= 1'b1;
        line_counter   <= spml_pkg::CNT_W'(1);
        match_counter  <= '0;
        skip_remaining <= '0;
      end else if (pop) begin
        line_counter   <= line_next;
        skip_remaining <= skip_next;
        if (out_ready) begin
          out_valid <= 1'b0;
        end
      end else if (pend_sum && out_free) begin
        out_valid      <= 1'b1;
        is_summary     <= 1'b1;
        line_number    <= line_counter;
        match_offset   <= '0;
        match_total    <= match_counter;
        last_result    <= 1'b1;
        line_counter   <= spml_pkg::CNT_W'(1);
        match_counter  <= '0;
        skip_remaining <= '0;
        pend_sum       <= 1'b0;
      end else begin
        if (out_ready) begin
          out_valid <= 1'b0;
        end
      end
    end
  end

endmodule

FILE: src/stream_pattern_matcher_lines_unit.sv
// a byte's result passes through a queue slot and then the output register
// throughput: one byte per cycle while the queue has room; a last-byte match adds a summary
// a 4-entry queue separates the window compare from the counters and output register
// reset (synchronous): pattern registers zero, line counter 1, match count and position zero
// after each summary the scan state returns to its reset value, pattern registers stay
module stream_pattern_matcher_lines_unit #(
  parameter int MAX_PATTERN_BYTES = spml_pkg::MAX_PATTERN_BYTES
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [spml_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [spml_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [7:0]                          data_byte,
  input  logic                                last_byte,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                is_summary,
  output logic [spml_pkg::CNT_W-1:0]          line_number,
  output logic [spml_pkg::CNT_W-1:0]          match_offset,
  output logic [spml_pkg::CNT_W-1:0]          match_total,
  output logic                                last_result
);

  logic            push;
  spml_pkg::cand_t push_entry;
  logic            queue_full;
  logic            pop;
  spml_pkg::cand_t head;
  logic            queue_empty;

  spml_front #(
    .MAX_PATTERN_BYTES(MAX_PATTERN_BYTES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .queue_full (queue_full),
    .push       (push),
    .push_entry (push_entry)
  );

  spml_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .head       (head),
    .empty      (queue_empty)
  );

  spml_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .empty        (queue_empty),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .is_summary   (is_summary),
    .line_number  (line_number),
    .match_offset (match_offset),
    .match_total  (match_total),
    .last_result  (last_result)
  );

endmodule

FILE: src/spml_checker.sv
module spml_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       is_summary,
  input logic [spml_pkg::CNT_W-1:0] line_number,
  input logic [spml_pkg::CNT_W-1:0] match_offset,
  input logic [spml_pkg::CNT_W-1:0] match_total,
  input logic                       last_result
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(is_summary) &&
    $stable(line_number) && $stable(match_offset) && $stable(match_total) &&
    $stable(last_result))
    else $error("result changed while stalled");

  a_summary_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_summary |-> last_result)
    else $error("summary without last_result");

  a_summary_offset: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_summary |-> match_offset == '0)
    else $error("summary with nonzero offset");

  a_line_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> line_number != '0)
    else $error("line number zero");

  a_match_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_summary |-> match_total != '0)
    else $error("match report with zero total");

endmodule

bind stream_pattern_matcher_lines_unit spml_checker u_spml_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .is_summary   (is_summary),
  .line_number  (line_number),
  .match_offset (match_offset),
  .match_total  (match_total),
  .last_result  (last_result)
);

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam logic [7:0] CHAR_A = 8'h61;
  localparam logic [7:0] CHAR_B = 8'h62;
  localparam logic [7:0] CHAR_C = 8'h63;

  typedef logic [7:0] byte_q_t[$];

  typedef struct packed {
    logic        summary;
    logic [31:0] line_no;
    logic [31:0] offset;
    logic [31:0] total;
    logic        closing;
  } match_report_t;

  class pattern_search_model;
    logic [4:0]    len_reg;
    logic [127:0]  pattern_bits;
    logic [7:0]    window[16];
    logic [3:0]    skip_left;
    logic [31:0]   line_cnt;
    logic [31:0]   hit_cnt;
    logic [31:0]   byte_pos;
    match_report_t expected_reports[$];
    int            mismatches;
    int            reports_seen;
    int            totals_seen;

    function new();
      len_reg = '0;
      pattern_bits = '0;
      mismatches = 0;
      reports_seen = 0;
      totals_seen = 0;
      restart();
    endfunction

    function void restart();
      foreach (window[k]) window[k] = 8'h00;
      skip_left = '0;
      line_cnt = 32'd1;
      hit_cnt = '0;
      byte_pos = '0;
    endfunction

    function logic [31:0] bump(logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    function void set_register(logic [spml_pkg::CFG_INDEX_W-1:0] idx, logic [63:0] value);
      case (idx)
        spml_pkg::CFG_PATTERN_LENGTH: len_reg = value[4:0];
        spml_pkg::CFG_PATTERN_LOW:    pattern_bits[63:0] = value;
        spml_pkg::CFG_PATTERN_HIGH:   pattern_bits[127:64] = value;
        default: ;
      endcase
    endfunction

    // a request was accepted: advance the scan and queue what it should produce
    function void take_byte(logic [7:0] data, logic is_last);
      int unsigned   span;
      logic [31:0]   start;
      bit            hit;
      int            k;
      match_report_t r;
      span = (len_reg > 5'd16) ? 16 : len_reg;
      start = byte_pos;
      for (k = 15; k > 0; k--) window[k] = window[k-1];
      window[0] = data;
      byte_pos = bump(byte_pos);
      if (span != 0 && {32'd0, start} + 64'd1 >= 64'(span)) begin
        if (skip_left != 0) begin
          skip_left = skip_left - 4'd1;
        end else begin
          if (window[span-1] == spml_pkg::NEWLINE_CODE) line_cnt = bump(line_cnt);
          hit = 1'b1;
          for (k = 0; k < span; k++) begin
            if (window[span-1-k] != pattern_bits[8*k +: 8]) hit = 1'b0;
          end
          if (hit) begin
            hit_cnt = bump(hit_cnt);
            skip_left = 4'(span - 1);
            r = '{1'b0, line_cnt, start - 32'(span - 1), hit_cnt, !is_last};
            expected_reports.push_back(r);
          end
        end
      end
      if (is_last) begin
        r = '{1'b1, line_cnt, 32'd0, hit_cnt, 1'b1};
        expected_reports.push_back(r);
        restart();
      end
    endfunction

    task report_error(string msg);
      $display("MISMATCH at %0t ns: %s", $time, msg);
      mismatches++;
    endtask

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report_error($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    endtask

    task check_report(match_report_t got);
      match_report_t want;
      if (expected_reports.size() == 0) begin
        report_error($sformatf("unexpected result summary=%0b line=%0d offset=%0d total=%0d",
                               got.summary, got.line_no, got.offset, got.total));
        return;
      end
      want = expected_reports.pop_front();
      if (want.summary) totals_seen++;
      else reports_seen++;
      compare_field("is_summary", 32'(got.summary), 32'(want.summary));
      compare_field("line_number", got.line_no, want.line_no);
      compare_field("match_offset", got.offset, want.offset);
      compare_field("match_total", got.total, want.total);
      compare_field("last_result", 32'(got.closing), 32'(want.closing));
    endtask
  endclass

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [spml_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [spml_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  logic [7:0]                       data_byte = '0;
  logic                             last_byte = 1'b0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic                             is_summary;
  logic [spml_pkg::CNT_W-1:0]       line_number;
  logic [spml_pkg::CNT_W-1:0]       match_offset;
  logic [spml_pkg::CNT_W-1:0]       match_total;
  logic                             last_result;

  pattern_search_model search = new();

  int         tx_mode = 0;
  int         rx_mode = 0;
  int         hold_cycles = 0;
  int         bytes_sent = 0;
  int         buffers_sent = 0;
  int         settings_used = 0;
  int         cur_len = 0;
  logic [7:0] cur_pattern[16];

  stream_pattern_matcher_lines_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .is_summary   (is_summary),
    .line_number  (line_number),
    .match_offset (match_offset),
    .match_total  (match_total),
    .last_result  (last_result)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int draw_gap(int mode);
    case (mode)
      0: return 0;
      1: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 14) : 0;
      default: return $urandom_range(0, 14);
    endcase
  endfunction

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 19);
    if (r < 8) return CHAR_A;
    if (r < 12) return CHAR_B;
    if (r < 15) return spml_pkg::NEWLINE_CODE;
    if (r == 15) return 8'h00;
    if (r == 16) return 8'hFF;
    return 8'($urandom);
  endfunction

  // random text with copies of the current pattern dropped in
  function automatic byte_q_t make_text(int size);
    byte_q_t q;
    int      k;
    while (q.size() < size) begin
      if (cur_len != 0 && $urandom_range(0, 3) == 0) begin
        for (k = 0; k < cur_len; k++) q.push_back(cur_pattern[k]);
      end else begin
        q.push_back(pick_byte());
      end
    end
    while (q.size() > size) void'(q.pop_back());
    return q;
  endfunction

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (search.expected_reports.size() != 0);
  endtask

  task automatic configure(input logic [spml_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    search.set_register(idx, value);
    @(posedge clk);
  endtask

  task automatic apply_settings(input logic [4:0] len, input logic [63:0] lo,
                                input logic [63:0] hi);
    logic [127:0] bits;
    int           k;
    drain_results();
    repeat (4) @(posedge clk);
    configure(spml_pkg::CFG_PATTERN_LENGTH, 64'(len));
    configure(spml_pkg::CFG_PATTERN_LOW, lo);
    configure(spml_pkg::CFG_PATTERN_HIGH, hi);
    bits = {hi, lo};
    cur_len = (len > 5'd16) ? 16 : len;
    for (k = 0; k < 16; k++) cur_pattern[k] = bits[8*k +: 8];
    settings_used++;
  endtask

  task automatic random_settings();
    logic [127:0] bits;
    logic [4:0]   len;
    int           r;
    int           k;
    r = $urandom_range(0, 9);
    if (r == 0) len = 5'd0;
    else if (r == 1) len = 5'($urandom_range(17, 31));
    else if (r < 4) len = 5'($urandom_range(5, 16));
    else len = 5'($urandom_range(1, 4));
    for (k = 0; k < 16; k++) bits[8*k +: 8] = pick_byte();
    if ($urandom_range(0, 7) == 0) bits[63:0] = {$urandom, $urandom};
    if ($urandom_range(0, 7) == 0) bits[127:64] = {$urandom, $urandom};
    apply_settings(len, bits[63:0], bits[127:64]);
  endtask

  task automatic send_buffer(input byte_q_t text, input int pause_at);
    int gap;
    int i;
    for (i = 0; i < text.size(); i++) begin
      if (i == pause_at || (i != 0 && $urandom_range(0, 79) == 0)) drain_results();
      gap = draw_gap(tx_mode);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid <= 1'b1;
      data_byte <= text[i];
      last_byte <= (i == text.size() - 1);
      do @(posedge clk); while (in_ready !== 1'b1);
      search.take_byte(text[i], i == text.size() - 1);
      bytes_sent++;
    end
    buffers_sent++;
  endtask

  // result side: random stalls, plus a long hold-off when one is requested
  initial begin : result_sink
    int            gap;
    match_report_t seen;
    forever begin
      if (hold_cycles != 0) begin
        gap = hold_cycles;
        hold_cycles = 0;
      end else begin
        gap = draw_gap(rx_mode);
      end
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (rst !== 1'b0 || out_valid !== 1'b1 || out_ready !== 1'b1);
      seen = '{is_summary, line_number, match_offset, match_total, last_result};
      search.check_report(seen);
    end
  end

  initial begin : stimulus
    byte_q_t text;
    int      k;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero length after reset: only a summary
    text = '{spml_pkg::NEWLINE_CODE};
    send_buffer(text, -1);

    // buffer shorter than the pattern
    apply_settings(5'd3, 64'h0000_0000_0063_6261, 64'd0);
    text = '{CHAR_A};
    send_buffer(text, -1);

    // newline at a visited start, skipped overlap, match on the last byte
    text = '{spml_pkg::NEWLINE_CODE, CHAR_A, CHAR_B, CHAR_C, CHAR_A, CHAR_B, CHAR_C};
    send_buffer(text, -1);

    // oversized length, zero and all-ones pattern bytes
    apply_settings(5'd31, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    text = {};
    for (k = 0; k < 8; k++) text.push_back(8'h00);
    for (k = 0; k < 8; k++) text.push_back(8'hFF);
    send_buffer(text, -1);

    // receiver holds off long while bytes keep coming, then sender waits for all results
    apply_settings(5'd1, 64'(CHAR_A), 64'd0);
    tx_mode = 0;
    rx_mode = 0;
    hold_cycles = 80;
    text = {};
    for (k = 0; k < 30; k++) text.push_back(CHAR_A);
    send_buffer(text, 20);

    while (bytes_sent < 650) begin
      if ($urandom_range(0, 2) == 0) random_settings();
      tx_mode = $urandom_range(0, 2);
      rx_mode = $urandom_range(0, 2);
      if ($urandom_range(0, 7) == 0) text = make_text($urandom_range(1, 4));
      else text = make_text($urandom_range(5, 40));
      send_buffer(text, -1);
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (search.expected_reports.size() != 0)
      search.report_error($sformatf("%0d results never arrived",
                                    search.expected_reports.size()));
    $display("covered %0d buffers, %0d bytes under %0d pattern settings",
             buffers_sent, bytes_sent, settings_used);
    $display("checked %0d match reports and %0d end-of-buffer totals",
             search.reports_seen, search.totals_seen);
    if (search.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("timeout, %0d results still pending", search.expected_reports.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
